// ===== hdl/attitude_frame_parser_defines.svh =====
// Assertion macros shared by the attitude frame parser checkers.
`ifndef ATTITUDE_FRAME_PARSER_DEFINES_SVH
`define ATTITUDE_FRAME_PARSER_DEFINES_SVH

// Same-cycle implication, sampled on clk, disabled while rst_n is low.
`define AFP_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("attitude frame parser check failed");

// Next-cycle implication, sampled on clk, disabled while rst_n is low.
`define AFP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("attitude frame parser check failed");

`endif

// ===== hdl/afp_pkg.sv =====
// Types and constants shared by the attitude frame parser modules.
package afp_pkg;

    // Field widths.
    localparam int BYTE_W    = 8;
    localparam int WORD_W    = 16;
    localparam int ANGLE_W   = 10;
    localparam int POS_W     = 3;
    localparam int CFG_IDX_W = 8;

    // Frame layout.
    localparam logic [BYTE_W-1:0] HEADER_BYTE  = 8'hAA;
    localparam logic [BYTE_W-1:0] TRAILER_BYTE = 8'h55;
    localparam logic [POS_W-1:0]  POS_HUNT     = 3'd0;
    localparam logic [POS_W-1:0]  POS_FIRST    = 3'd1;
    localparam logic [POS_W-1:0]  POS_LAST     = 3'd7;
    localparam int                PAYLOAD_LEN  = 6;

    // Division by 100: multiply by ceil(2^23 / 100) and keep the upper bits.
    // Exact for every 16-bit dividend.
    localparam int                RECIP_SHIFT = 23;
    localparam int                RECIP_W     = 17;
    localparam logic [RECIP_W-1:0] RECIP_100  = 17'd83887;
    localparam int                PROD_W      = WORD_W + RECIP_W;

    // Largest angle a 16-bit word can give.
    localparam logic [ANGLE_W-1:0] ANGLE_MAX = 10'd655;

    // Register indexes and reset values.
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_LIMIT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_FOLD  = 8'd1;
    localparam logic [ANGLE_W-1:0]   LIMIT_RESET     = 10'd360;
    localparam logic [ANGLE_W-1:0]   FOLD_RESET      = 10'd300;

    // Configuration register contents.
    typedef struct packed {
        logic [ANGLE_W-1:0] angle_limit;
        logic [ANGLE_W-1:0] angle_fold;
    } cfg_t;

    // Payload words of one complete frame.
    typedef struct packed {
        logic [WORD_W-1:0] yaw_word;
        logic [WORD_W-1:0] roll_word;
        logic [WORD_W-1:0] pitch_word;
    } frame_t;

endpackage

// ===== hdl/afp_cfg_regs.sv =====
// Configuration registers for the angle limit and fold amount.
module afp_cfg_regs
    import afp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ANGLE_W-1:0]   cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Writes are always taken; unknown indexes are dropped.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_ANGLE_LIMIT: cfg_next.angle_limit = cfg_data;
                REG_ANGLE_FOLD:  cfg_next.angle_fold  = cfg_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.angle_limit <= LIMIT_RESET;
            cfg_reg.angle_fold  <= FOLD_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hdl/afp_frame_collector.sv =====
// Header hunt, payload capture and trailer check for incoming bytes.
module afp_frame_collector
    import afp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [BYTE_W-1:0] rx_byte,
    output logic              frame_valid,
    input  logic              frame_ready,
    output frame_t            frame
);

    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic              frame_valid_reg;
    logic              frame_valid_next;
    logic              load_frame;
    logic              in_accept;
    logic              store_payload;
    logic [POS_W-1:0]  payload_idx;
    logic [BYTE_W-1:0] payload_reg [PAYLOAD_LEN];
    frame_t            frame_reg;

    // A byte can always be taken unless a finished frame is still waiting.
    assign in_ready  = !frame_valid_reg || frame_ready;
    assign in_accept = in_valid && in_ready;

    // Frame position tracking and trailer check.
    always_comb
    begin
        pos_next         = pos_reg;
        frame_valid_next = frame_valid_reg && !frame_ready;
        load_frame       = 1'b0;
        store_payload    = 1'b0;
        if (in_accept)
        begin
            case (pos_reg)
                POS_HUNT:
                begin
                    if (rx_byte == HEADER_BYTE)
                    begin
                        pos_next = POS_FIRST;
                    end
                end
                POS_LAST:
                begin
                    pos_next = POS_HUNT;
                    if (rx_byte == TRAILER_BYTE)
                    begin
                        load_frame       = 1'b1;
                        frame_valid_next = 1'b1;
                    end
                end
                default:
                begin
                    store_payload = 1'b1;
                    pos_next      = pos_reg + POS_FIRST;
                end
            endcase
        end
    end

    assign payload_idx = pos_reg - POS_FIRST;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= POS_HUNT;
            frame_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg         <= pos_next;
            frame_valid_reg <= frame_valid_next;
        end
    end

    // Payload bytes 1 to 6 of the frame in progress.
    always_ff @(posedge clk)
    begin
        if (store_payload)
        begin
            payload_reg[payload_idx] <= rx_byte;
        end
    end

    // Snapshot of the big-endian words once the trailer checks out.
    always_ff @(posedge clk)
    begin
        if (load_frame)
        begin
            frame_reg.yaw_word   <= {payload_reg[0], payload_reg[1]};
            frame_reg.roll_word  <= {payload_reg[2], payload_reg[3]};
            frame_reg.pitch_word <= {payload_reg[4], payload_reg[5]};
        end
    end

    assign frame_valid = frame_valid_reg;
    assign frame       = frame_reg;

endmodule

// ===== hdl/afp_angle_decode.sv =====
// Divide-by-100 and fold of the three angles, with the output register.
module afp_angle_decode
    import afp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               frame_valid,
    output logic               frame_ready,
    input  frame_t             frame,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [ANGLE_W-1:0] pitch_deg,
    output logic [ANGLE_W-1:0] roll_deg,
    output logic [ANGLE_W-1:0] yaw_deg
);

    logic               out_valid_reg;
    logic               out_valid_next;
    logic               load_out;
    logic [ANGLE_W-1:0] pitch_next;
    logic [ANGLE_W-1:0] roll_next;
    logic [ANGLE_W-1:0] yaw_next;
    logic [ANGLE_W-1:0] pitch_reg;
    logic [ANGLE_W-1:0] roll_reg;
    logic [ANGLE_W-1:0] yaw_reg;

    // Word / 100 by reciprocal multiply, then fold above the limit.
    function automatic logic [ANGLE_W-1:0] decode_angle(
        input logic [WORD_W-1:0]  word,
        input logic [ANGLE_W-1:0] limit,
        input logic [ANGLE_W-1:0] fold
    );
        logic [PROD_W-1:0]  prod;
        logic [ANGLE_W-1:0] quot;
        logic [ANGLE_W-1:0] res;
        prod = PROD_W'(word) * PROD_W'(RECIP_100);
        quot = prod[RECIP_SHIFT +: ANGLE_W];
        res  = quot;
        if (quot > limit)
        begin
            res = (quot >= fold) ? (quot - fold) : '0;
        end
        return res;
    endfunction

    assign pitch_next = decode_angle(frame.pitch_word, cfg.angle_limit, cfg.angle_fold);
    assign roll_next  = decode_angle(frame.roll_word,  cfg.angle_limit, cfg.angle_fold);
    assign yaw_next   = decode_angle(frame.yaw_word,   cfg.angle_limit, cfg.angle_fold);

    // Output register takes a new frame when empty or being drained.
    assign frame_ready = !out_valid_reg || out_ready;
    assign load_out    = frame_valid && frame_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            pitch_reg <= pitch_next;
            roll_reg  <= roll_next;
            yaw_reg   <= yaw_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign pitch_deg = pitch_reg;
    assign roll_deg  = roll_reg;
    assign yaw_deg   = yaw_reg;

endmodule

// ===== hdl/attitude_frame_parser.sv =====
// Attitude frame parser: serial bytes in, decoded angle triples out.
//
// The input channel (in_valid, in_ready, rx_byte) takes one received byte
// per item. Bytes are framed as header 0xAA, six payload bytes and
// trailer 0x55; bytes other than the header are dropped while hunting.
// A frame with a good trailer gives one output item (pitch_deg, roll_deg,
// yaw_deg), each a big-endian payload word divided by 100 and folded by
// angle_fold when above angle_limit. A bad trailer gives nothing.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data)
// writes angle_limit at index 0 and angle_fold at index 1 and is always
// ready; other indexes are ignored.
// Throughput is one byte per cycle while in_ready is high. After its trailer
// byte is taken, an output item passes the frame register and then the
// output register, with the divide and fold between them.
// When the receiver stalls, the output register holds its item and the
// frame register can hold one more; in_ready drops only while both are
// full. Reset returns to the header hunt, empties both registers and
// loads angle_limit with 360 and angle_fold with 300.
module attitude_frame_parser
    import afp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [BYTE_W-1:0]    rx_byte,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [ANGLE_W-1:0]   pitch_deg,
    output logic [ANGLE_W-1:0]   roll_deg,
    output logic [ANGLE_W-1:0]   yaw_deg,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ANGLE_W-1:0]   cfg_data
);

    cfg_t   cfg;
    frame_t frame;
    logic   frame_valid;
    logic   frame_ready;

    // Configuration registers.
    afp_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Frame assembly.
    afp_frame_collector u_collector (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .rx_byte     (rx_byte),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .frame       (frame)
    );

    // Angle decode and output register.
    afp_angle_decode u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .frame       (frame),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pitch_deg   (pitch_deg),
        .roll_deg    (roll_deg),
        .yaw_deg     (yaw_deg)
    );

endmodule

// ===== hdl/afp_checker.sv =====
// Port-level checks for the attitude frame parser, bound to the top level.
`include "attitude_frame_parser_defines.svh"

module afp_checker
    import afp_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic [BYTE_W-1:0]  rx_byte,
    input logic               out_valid,
    input logic               out_ready,
    input logic [ANGLE_W-1:0] pitch_deg,
    input logic [ANGLE_W-1:0] roll_deg,
    input logic [ANGLE_W-1:0] yaw_deg
);

    logic out_stall;
    logic trailer_taken;
    logic angles_in_range;

    // Handshake and range terms used by the checks below.
    assign out_stall       = out_valid && !out_ready;
    assign trailer_taken   = in_valid && in_ready && (rx_byte == TRAILER_BYTE);
    assign angles_in_range = (pitch_deg <= ANGLE_MAX) && (roll_deg <= ANGLE_MAX)
                             && (yaw_deg <= ANGLE_MAX);

    // A stalled output item keeps its valid and its angles.
    `AFP_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable({pitch_deg, roll_deg, yaw_deg}))

    // A fresh output item follows a taken trailer byte.
    `AFP_ASSERT_IMPL(a_out_after_trailer, $rose(out_valid), $past(trailer_taken, 2))

    // Input backpressure only comes from a stalled receiver.
    `AFP_ASSERT_IMPL(a_in_stall_cause, !in_ready, out_stall)

    // Decoded angles never exceed what a 16-bit word divided by 100 allows.
    `AFP_ASSERT_IMPL(a_angle_range, out_valid, angles_in_range)

endmodule

bind attitude_frame_parser afp_checker u_afp_checker (.*);
